// ===== sv/i2cts_pkg.sv =====
// ---------------------------------------------------------------------------
// I2C transaction sequencer package
// Beat types, bus command codes, request codes and status codes.
// ---------------------------------------------------------------------------
package i2cts_pkg;

  localparam int COUNT_MAX_DEF = 255;

  // request codes
  localparam logic [1:0] FUNC_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_STEP  = 2'd2;

  // bus engine commands
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_SEND   = 3'd2;
  localparam logic [2:0] CMD_RSTART = 3'd3;
  localparam logic [2:0] CMD_RECV   = 3'd4;
  localparam logic [2:0] CMD_ACK    = 3'd5;
  localparam logic [2:0] CMD_STOP   = 3'd6;

  // completion status
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_NOTHING     = 4'd1;
  localparam logic [3:0] ST_COLL_START  = 4'd2;
  localparam logic [3:0] ST_COLL_ADDR   = 4'd3;
  localparam logic [3:0] ST_NACK_ADDR   = 4'd4;
  localparam logic [3:0] ST_COLL_DATA   = 4'd5;
  localparam logic [3:0] ST_NACK_DATA   = 4'd6;
  localparam logic [3:0] ST_COLL_RSTART = 4'd7;
  localparam logic [3:0] ST_COLL_RADDR  = 4'd8;
  localparam logic [3:0] ST_NACK_RADDR  = 4'd9;
  localparam logic [3:0] ST_COLL_RECV   = 4'd10;
  localparam logic [3:0] ST_COLL_ACK    = 4'd11;
  localparam logic [3:0] ST_COLL_STOP   = 4'd12;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] address;
    logic [7:0] write_count;
    logic [7:0] read_count;
    logic [7:0] write_byte;
    logic       collision;
    logic       nack;
    logic [7:0] rx_byte;
    logic       bus_started;
  } in_item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       need_write;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [3:0] status;
    logic [7:0] read_total;
  } out_item_t;

endpackage

// ===== sv/i2cts_core.sv =====
// ---------------------------------------------------------------------------
// I2C transaction sequencer core
// Transaction state and the single-pass decision logic for one beat.
// ---------------------------------------------------------------------------
module i2cts_core
  import i2cts_pkg::*;
#(
  parameter int COUNT_MAX = COUNT_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_ADDR, PH_WANT, PH_DATA,
    PH_RSTART, PH_RADDR, PH_RECV, PH_ACK, PH_STOP
  } phase_t;

  phase_t     phase, phase_next;
  logic [6:0] target, target_next;
  logic [7:0] writes_left, writes_left_next;
  logic [7:0] reads_left, reads_left_next;
  logic       write_phase_used, write_phase_used_next;
  logic [7:0] reads_done, reads_done_next;

  logic       fail;
  logic [3:0] fail_code;
  logic [7:0] wl_dec, rl_dec, wl_clip, rl_clip;

  function automatic logic [7:0] clip(input logic [7:0] v);
    logic [7:0] c;
    c = v;
    if (32'(v) > COUNT_MAX) c = 8'(COUNT_MAX);
    return c;
  endfunction

  always_comb begin
    res                   = '0;
    phase_next            = phase;
    target_next           = target;
    writes_left_next      = writes_left;
    reads_left_next       = reads_left;
    write_phase_used_next = write_phase_used;
    reads_done_next       = reads_done;
    fail                  = 1'b0;
    fail_code             = ST_OK;
    wl_clip               = clip(item.write_count);
    rl_clip               = clip(item.read_count);
    wl_dec                = (writes_left != 8'd0) ? writes_left - 8'd1 : 8'd0;
    rl_dec                = (reads_left != 8'd0) ? reads_left - 8'd1 : 8'd0;

    case (item.func)
      FUNC_BEGIN: begin
        if (phase == PH_IDLE) begin
          target_next           = item.address;
          writes_left_next      = wl_clip;
          reads_left_next       = rl_clip;
          reads_done_next       = 8'd0;
          write_phase_used_next = (wl_clip != 8'd0);
          if (wl_clip == 8'd0 && rl_clip == 8'd0) begin
            res.done_res = 1'b1;
            res.status   = ST_NOTHING;
          end else begin
            res.command = CMD_START;
            phase_next  = PH_START;
          end
        end
      end
      FUNC_WRITE: begin
        if (phase == PH_WANT) begin
          res.command = CMD_SEND;
          res.tx_byte = item.write_byte;
          phase_next  = PH_DATA;
        end
      end
      FUNC_STEP: begin
        case (phase)
          PH_START: begin
            if (item.collision) begin
              fail = 1'b1; fail_code = ST_COLL_START;
            end else begin
              res.command = CMD_SEND;
              res.tx_byte = {target, ~write_phase_used};
              phase_next  = PH_ADDR;
            end
          end
          PH_ADDR: begin
            if (item.collision) begin
              fail = 1'b1; fail_code = ST_COLL_ADDR;
            end else if (item.nack) begin
              fail = 1'b1; fail_code = ST_NACK_ADDR;
            end else if (write_phase_used) begin
              res.need_write = 1'b1;
              phase_next     = PH_WANT;
            end else begin
              res.command = CMD_RECV;
              phase_next  = PH_RECV;
            end
          end
          PH_DATA: begin
            if (item.collision) begin
              fail = 1'b1; fail_code = ST_COLL_DATA;
            end else if (item.nack) begin
              fail = 1'b1; fail_code = ST_NACK_DATA;
            end else begin
              writes_left_next = wl_dec;
              if (wl_dec != 8'd0) begin
                res.need_write = 1'b1;
                phase_next     = PH_WANT;
              end else if (reads_left != 8'd0) begin
                res.command = CMD_RSTART;
                phase_next  = PH_RSTART;
              end else begin
                res.command = CMD_STOP;
                phase_next  = PH_STOP;
              end
            end
          end
          PH_RSTART: begin
            if (item.collision) begin
              fail = 1'b1; fail_code = ST_COLL_RSTART;
            end else begin
              res.command = CMD_SEND;
              res.tx_byte = {target, 1'b1};
              phase_next  = PH_RADDR;
            end
          end
          PH_RADDR: begin
            if (item.collision) begin
              fail = 1'b1; fail_code = ST_COLL_RADDR;
            end else if (item.nack) begin
              fail = 1'b1; fail_code = ST_NACK_RADDR;
            end else begin
              res.command = CMD_RECV;
              phase_next  = PH_RECV;
            end
          end
          PH_RECV: begin
            if (item.collision) begin
              fail = 1'b1; fail_code = ST_COLL_RECV;
            end else begin
              res.read_valid = 1'b1;
              res.read_byte  = item.rx_byte;
              if (reads_done != 8'hFF) reads_done_next = reads_done + 8'd1;
              res.command    = CMD_ACK;
              // NACK the final byte
              res.ack_bit    = (reads_left <= 8'd1);
              phase_next     = PH_ACK;
            end
          end
          PH_ACK: begin
            if (item.collision) begin
              fail = 1'b1; fail_code = ST_COLL_ACK;
            end else begin
              reads_left_next = rl_dec;
              if (rl_dec != 8'd0) begin
                res.command = CMD_RECV;
                phase_next  = PH_RECV;
              end else begin
                res.command = CMD_STOP;
                phase_next  = PH_STOP;
              end
            end
          end
          PH_STOP: begin
            if (item.collision) begin
              fail = 1'b1; fail_code = ST_COLL_STOP;
            end else begin
              res.done_res   = 1'b1;
              res.status     = ST_OK;
              res.read_total = reads_done;
              phase_next     = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // abort: release the bus if still held, drop back to idle
    if (fail) begin
      res.command    = item.bus_started ? CMD_STOP : CMD_NONE;
      res.done_res   = 1'b1;
      res.status     = fail_code;
      res.read_total = reads_done;
      phase_next     = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      target           <= '0;
      writes_left      <= '0;
      reads_left       <= '0;
      write_phase_used <= 1'b0;
      reads_done       <= '0;
    end else if (fire) begin
      phase            <= phase_next;
      target           <= target_next;
      writes_left      <= writes_left_next;
      reads_left       <= reads_left_next;
      write_phase_used <= write_phase_used_next;
      reads_done       <= reads_done_next;
    end
  end

endmodule

// ===== sv/i2c_master_transaction_sequencer.sv =====
// ---------------------------------------------------------------------------
// I2C master transaction sequencer
// Drives a byte-level I2C engine through one write and/or read transfer.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_item carry request beats: begin a transfer, supply
//   the next write byte, or report a completed engine step. out_valid/
//   out_stall/out_item carry exactly one result beat per request beat, in
//   order: the next engine command, a write-byte request, a received byte,
//   and at the end a done flag with status and read total.
//   Path: a beat accepted into the input register passes through one pass
//   of decision logic into the result register.
//   Throughput: one beat per cycle while out_stall is low; the transaction
//   state updates within the single decision pass, so consecutive beats
//   never wait on each other.
//   Stall: while the result register is held by out_stall, the input
//   register holds its beat and in_stall rises once that register is full.
//   Reset: synchronous; clears both registers' valid flags and returns the
//   sequencer to idle with all counters at zero.
// ---------------------------------------------------------------------------
module i2c_master_transaction_sequencer
  import i2cts_pkg::*;
#(
  parameter int COUNT_MAX = COUNT_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      in_full;
  in_item_t  in_reg;
  logic      fire;
  out_item_t res;

  // process the held beat whenever the result register can take it
  assign fire     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !fire;

  i2cts_core #(
    .COUNT_MAX (COUNT_MAX)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_reg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= res;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// I2C transaction sequencer testbench
// Drives request beats (begin, write byte, engine step) through the
// valid/stall channel, takes each expected result from the script or a
// behavioural model of the sequencer and checks it field by field, in order.
// A short scripted opening covers the corner cases, then random traffic
// runs mostly well-formed transfers with occasional stray requests.
// ---------------------------------------------------------------------------
module testbench;
  import i2cts_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam out_item_t  IGNORED     = '0;
  localparam int         BEAT_TARGET = 1000;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_ADDR, PH_WANT, PH_DATA,
    PH_RSTART, PH_RADDR, PH_RECV, PH_ACK, PH_STOP
  } xfer_phase_t;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // sequencer model state
  xfer_phase_t xfer_phase = PH_IDLE;
  logic [6:0]  xfer_target = '0;
  logic [7:0]  writes_pending = '0;
  logic [7:0]  reads_pending = '0;
  logic        has_write_phase = 1'b0;
  logic [7:0]  bytes_read = '0;

  out_item_t   pending_results[$];
  script_row_t script[$];
  out_item_t   oldest;
  bit          failed = 1'b0;
  int          live_beats = 0;
  int unsigned send_idle = 16;
  int unsigned recv_idle = 66;

  i2c_master_transaction_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic in_item_t beat(logic [1:0] func, logic [6:0] addr, logic [7:0] wc,
                                    logic [7:0] rc, logic [7:0] wb, logic coll, logic nak,
                                    logic [7:0] rx, logic started);
    in_item_t b;
    b.func        = func;
    b.address     = addr;
    b.write_count = wc;
    b.read_count  = rc;
    b.write_byte  = wb;
    b.collision   = coll;
    b.nack        = nak;
    b.rx_byte     = rx;
    b.bus_started = started;
    return b;
  endfunction

  function automatic out_item_t res(logic [2:0] cmd, logic [7:0] tx, logic ack, logic nw,
                                    logic rv, logic [7:0] rb, logic dn, logic [3:0] st,
                                    logic [7:0] tot);
    out_item_t r;
    r.command    = cmd;
    r.tx_byte    = tx;
    r.ack_bit    = ack;
    r.need_write = nw;
    r.read_valid = rv;
    r.read_byte  = rb;
    r.done_res   = dn;
    r.status     = st;
    r.read_total = tot;
    return r;
  endfunction

  function automatic script_row_t row(in_item_t stim, bit typed, out_item_t want);
    script_row_t s;
    s.stim  = stim;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  // Drop the transfer: stop only if the bus is still held.
  function automatic void abort_transfer(inout out_item_t r, input logic [3:0] code,
                                         input logic started);
    r.command    = started ? CMD_STOP : CMD_NONE;
    r.done_res   = 1'b1;
    r.status     = code;
    r.read_total = bytes_read;
    xfer_phase   = PH_IDLE;
  endfunction

  function automatic out_item_t sequence_result(input in_item_t b);
    out_item_t r;
    r = '0;
    case (b.func)
      FUNC_BEGIN: if (xfer_phase == PH_IDLE) begin
        xfer_target     = b.address;
        writes_pending  = b.write_count;
        reads_pending   = b.read_count;
        bytes_read      = '0;
        has_write_phase = (b.write_count != 8'd0);
        if (b.write_count == 8'd0 && b.read_count == 8'd0) begin
          r.done_res = 1'b1;
          r.status   = ST_NOTHING;
        end else begin
          r.command  = CMD_START;
          xfer_phase = PH_START;
        end
      end
      FUNC_WRITE: if (xfer_phase == PH_WANT) begin
        r.command  = CMD_SEND;
        r.tx_byte  = b.write_byte;
        xfer_phase = PH_DATA;
      end
      FUNC_STEP: begin
        case (xfer_phase)
          PH_START: if (b.collision) abort_transfer(r, ST_COLL_START, b.bus_started);
          else begin
            r.command  = CMD_SEND;
            r.tx_byte  = {xfer_target, ~has_write_phase};
            xfer_phase = PH_ADDR;
          end
          PH_ADDR: if (b.collision) abort_transfer(r, ST_COLL_ADDR, b.bus_started);
          else if (b.nack) abort_transfer(r, ST_NACK_ADDR, b.bus_started);
          else if (has_write_phase) begin
            r.need_write = 1'b1;
            xfer_phase   = PH_WANT;
          end else begin
            r.command  = CMD_RECV;
            xfer_phase = PH_RECV;
          end
          PH_DATA: if (b.collision) abort_transfer(r, ST_COLL_DATA, b.bus_started);
          else if (b.nack) abort_transfer(r, ST_NACK_DATA, b.bus_started);
          else begin
            if (writes_pending != 8'd0) writes_pending = writes_pending - 8'd1;
            if (writes_pending != 8'd0) begin
              r.need_write = 1'b1;
              xfer_phase   = PH_WANT;
            end else if (reads_pending != 8'd0) begin
              r.command  = CMD_RSTART;
              xfer_phase = PH_RSTART;
            end else begin
              r.command  = CMD_STOP;
              xfer_phase = PH_STOP;
            end
          end
          PH_RSTART: if (b.collision) abort_transfer(r, ST_COLL_RSTART, b.bus_started);
          else begin
            r.command  = CMD_SEND;
            r.tx_byte  = {xfer_target, 1'b1};
            xfer_phase = PH_RADDR;
          end
          PH_RADDR: if (b.collision) abort_transfer(r, ST_COLL_RADDR, b.bus_started);
          else if (b.nack) abort_transfer(r, ST_NACK_RADDR, b.bus_started);
          else begin
            r.command  = CMD_RECV;
            xfer_phase = PH_RECV;
          end
          PH_RECV: if (b.collision) abort_transfer(r, ST_COLL_RECV, b.bus_started);
          else begin
            r.read_valid = 1'b1;
            r.read_byte  = b.rx_byte;
            if (bytes_read != 8'hFF) bytes_read = bytes_read + 8'd1;
            r.command    = CMD_ACK;
            r.ack_bit    = (reads_pending <= 8'd1);
            xfer_phase   = PH_ACK;
          end
          PH_ACK: if (b.collision) abort_transfer(r, ST_COLL_ACK, b.bus_started);
          else begin
            if (reads_pending != 8'd0) reads_pending = reads_pending - 8'd1;
            r.command  = (reads_pending != 8'd0) ? CMD_RECV : CMD_STOP;
            xfer_phase = (reads_pending != 8'd0) ? PH_RECV : PH_STOP;
          end
          PH_STOP: if (b.collision) abort_transfer(r, ST_COLL_STOP, b.bus_started);
          else begin
            r.done_res   = 1'b1;
            r.status     = ST_OK;
            r.read_total = bytes_read;
            xfer_phase   = PH_IDLE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2) return 8'hFF;
    if (roll < 10) return 8'($urandom_range(255));
    return 8'($urandom_range(3));
  endfunction

  // Mostly the request the sequencer is waiting for, with random content.
  function automatic in_item_t next_request();
    in_item_t    b;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    b = raw[$bits(in_item_t)-1:0];
    b.collision = ($urandom_range(99) < 4);
    b.nack      = ($urandom_range(99) < 5);
    if ($urandom_range(99) < 8) begin
      b.func = 2'($urandom_range(3));
      return b;
    end
    case (xfer_phase)
      PH_IDLE: begin
        b.func        = FUNC_BEGIN;
        b.write_count = pick_count();
        b.read_count  = pick_count();
      end
      PH_WANT: b.func = FUNC_WRITE;
      default: b.func = FUNC_STEP;
    endcase
    return b;
  endfunction

  task automatic send_request(input in_item_t b, input bit typed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = sequence_result(b);
    pending_results.push_back(typed ? want : predicted);
    // ignored requests answer all zero
    if (predicted != IGNORED) live_beats++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got %h",
                 $time, out_item);
        failed = 1'b1;
      end else begin
        oldest = pending_results.pop_front();
        check_field("command", 8'(oldest.command), 8'(out_item.command));
        check_field("tx_byte", oldest.tx_byte, out_item.tx_byte);
        check_field("ack_bit", 8'(oldest.ack_bit), 8'(out_item.ack_bit));
        check_field("need_write", 8'(oldest.need_write), 8'(out_item.need_write));
        check_field("read_valid", 8'(oldest.read_valid), 8'(out_item.read_valid));
        check_field("read_byte", oldest.read_byte, out_item.read_byte);
        check_field("done_res", 8'(oldest.done_res), 8'(out_item.done_res));
        check_field("status", 8'(oldest.status), 8'(out_item.status));
        check_field("read_total", oldest.read_total, out_item.read_total);
      end
    end
  end

  initial begin
    // stray requests straight after reset
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0),
                         1'b1, IGNORED));
    script.push_back(row(beat(FUNC_WRITE, 7'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1),
                         1'b1, IGNORED));
    script.push_back(row(beat(FUNC_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1),
                         1'b1, IGNORED));
    // nothing to do
    script.push_back(row(beat(FUNC_BEGIN, 7'h7F, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0),
                         1'b1, res(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, ST_NOTHING,
                                   8'h00)));
    // one write then one read, top address
    script.push_back(row(beat(FUNC_BEGIN, 7'h7F, 8'h01, 8'h01, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0),
                         1'b1, res(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK,
                                   8'h00)));
    script.push_back(row(beat(FUNC_BEGIN, 7'h00, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0),
                         1'b1, IGNORED));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1),
                         1'b1, res(CMD_SEND, 8'hFE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK,
                                   8'h00)));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1),
                         1'b1, res(CMD_NONE, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, ST_OK,
                                   8'h00)));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1),
                         1'b1, IGNORED));
    script.push_back(row(beat(FUNC_WRITE, 7'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b1),
                         1'b1, res(CMD_SEND, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK,
                                   8'h00)));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1),
                         1'b1, res(CMD_RSTART, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK,
                                   8'h00)));
    // nack on a repeated start sent no byte, so it does not count
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1),
                         1'b1, res(CMD_SEND, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK,
                                   8'h00)));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1),
                         1'b1, res(CMD_RECV, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK,
                                   8'h00)));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'hA5, 1'b1),
                         1'b1, res(CMD_ACK, 8'h00, 1'b1, 1'b0, 1'b1, 8'hA5, 1'b0, ST_OK,
                                   8'h00)));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1),
                         1'b1, res(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK,
                                   8'h00)));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0),
                         1'b1, res(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, ST_OK,
                                   8'h01)));
    // read-only transfer, collision and nack together on the ack bit
    script.push_back(row(beat(FUNC_BEGIN, 7'h55, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0),
                         1'b0, IGNORED));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1),
                         1'b0, IGNORED));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1),
                         1'b0, IGNORED));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h5A, 1'b1),
                         1'b0, IGNORED));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1),
                         1'b1, res(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, ST_COLL_ACK,
                                   8'h01)));
    // collision at start with the bus already released
    script.push_back(row(beat(FUNC_BEGIN, 7'h01, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0),
                         1'b0, IGNORED));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0),
                         1'b1, res(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
                                   ST_COLL_START, 8'h00)));
    // address nack
    script.push_back(row(beat(FUNC_BEGIN, 7'h02, 8'h02, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0),
                         1'b0, IGNORED));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1),
                         1'b0, IGNORED));
    script.push_back(row(beat(FUNC_STEP, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1),
                         1'b1, res(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1,
                                   ST_NACK_ADDR, 8'h00)));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_request(script[i].stim, script[i].typed, script[i].want);

    while (live_beats < BEAT_TARGET) begin
      if (live_beats >= 2 * BEAT_TARGET / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (live_beats >= BEAT_TARGET / 3) begin
        send_idle = 66;
        recv_idle = 16;
      end
      send_request(next_request(), 1'b0, IGNORED);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
